// ----- sv/integer_batch_sorter_top_defines.svh -----
// ---------------------------------------------------------------------------
// integer batch sorter assertion macros
// shared concurrent check forms, clocked on clk and quiet during rst
// ---------------------------------------------------------------------------
`ifndef INTEGER_BATCH_SORTER_TOP_DEFINES_SVH
`define INTEGER_BATCH_SORTER_TOP_DEFINES_SVH

// same-cycle implication check
`define IBS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define IBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ibs_pkg.sv -----
// ---------------------------------------------------------------------------
// ibs_pkg
// shared types and constants of the integer batch sorter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ibs_pkg;

  // value field width and the byte-padded stream data width
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned DATA_W  = 32;

  // controller states
  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // store the accepted request
    logic shift;  // result taken, advance the sorted row
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last_one;  // exactly one value left in the row
  } status_t;

endpackage

// ----- sv/integer_batch_sorter_top.sv -----
// loading: a batch of n values loads one request per cycle; the first result
//   is offered the cycle after the final request is taken
// rates: requests enter through a single load port and results leave one per
//   cycle while m_tready is high, through the single head cell of the sorted row
// reset: rst clears the state machine, fill count and overflow flag; value
//   cells are not reset and are only read once written
// ---------------------------------------------------------------------------
// integer_batch_sorter_top
// batch sorter: stores a run of values, emits them ascending after tlast
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_batch_sorter_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ibs_pkg::DATA_W-1:0]  s_tdata,   // [30:0] value, [31] zero
  input  logic                        s_tlast,   // is_final
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ibs_pkg::DATA_W-1:0]  m_tdata,   // [30:0] sorted_value, [31] zero
  output logic                        m_tlast,   // last_out
  output logic                        m_tuser    // [0] overflow
);

  ibs_pkg::cmd_t               cmd;
  ibs_pkg::status_t            status;
  logic [ibs_pkg::VALUE_W-1:0] head_value;

  // controller
  ibs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // sorted row datapath
  ibs_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_value   (s_tdata[ibs_pkg::VALUE_W-1:0]),
    .status     (status),
    .head_value (head_value),
    .last_out   (m_tlast),
    .overflow   (m_tuser)
  );

  // pad result to whole bytes
  assign m_tdata = {{(ibs_pkg::DATA_W - ibs_pkg::VALUE_W){1'b0}}, head_value};

endmodule

// ----- sv/ibs_ctrl.sv -----
// ---------------------------------------------------------------------------
// ibs_ctrl
// load/emit state machine driving the sorted-row datapath
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_batch_sorter_top_defines.svh"

module ibs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ibs_pkg::status_t  status,
  output ibs_pkg::cmd_t     cmd
);

  ibs_pkg::state_t state;
  ibs_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ibs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ibs_pkg::ST_LOAD: begin
        if (s_tvalid && s_tlast) begin
          state_next = ibs_pkg::ST_EMIT;
        end
      end
      ibs_pkg::ST_EMIT: begin
        if (m_tready && status.last_one) begin
          state_next = ibs_pkg::ST_LOAD;
        end
      end
      default: state_next = ibs_pkg::ST_LOAD;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    cmd.load  = 1'b0;
    cmd.shift = 1'b0;
    unique case (state)
      ibs_pkg::ST_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ibs_pkg::ST_EMIT: begin
        m_tvalid  = 1'b1;
        cmd.shift = m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // checks
  `IBS_ASSERT_NEXT(a_final_starts_emit, s_tvalid && s_tready && s_tlast, m_tvalid && !s_tready, "final request did not start result output")
  `IBS_ASSERT_NEXT(a_last_ends_emit, m_tvalid && m_tready && status.last_one, s_tready && !m_tvalid, "last result did not return to loading")

endmodule

// ----- sv/ibs_datapath.sv -----
// ---------------------------------------------------------------------------
// ibs_datapath
// row of compare/insert cells kept in ascending order, shifted out in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_batch_sorter_top_defines.svh"

module ibs_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ibs_pkg::cmd_t                cmd,
  input  logic [ibs_pkg::VALUE_W-1:0]  in_value,
  output ibs_pkg::status_t             status,
  output logic [ibs_pkg::VALUE_W-1:0]  head_value,
  output logic                         last_out,
  output logic                         overflow
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [ibs_pkg::VALUE_W-1:0] cells      [MAX_ITEMS];
  logic [ibs_pkg::VALUE_W-1:0] cells_next [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]        gt;
  logic [CNT_W-1:0]            count;
  logic                        dropped;
  logic                        full;

  assign full            = (count == CNT_W'(MAX_ITEMS));
  assign status.last_one = (count == CNT_W'(1));

  // per-cell compare and insert/shift selection
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign gt[i] = (count > CNT_W'(i)) && (cells[i] > in_value);

    always_comb begin
      cells_next[i] = cells[i];
      if (cmd.shift) begin
        if (i < MAX_ITEMS - 1) begin
          cells_next[i] = cells[(i + 1) % MAX_ITEMS];
        end
      end else if (cmd.load && !full) begin
        if (i > 0 && gt[(i + MAX_ITEMS - 1) % MAX_ITEMS]) begin
          cells_next[i] = cells[(i + MAX_ITEMS - 1) % MAX_ITEMS];
        end else if (gt[i] || count == CNT_W'(i)) begin
          cells_next[i] = in_value;
        end
      end
    end

    always_ff @(posedge clk) begin
      cells[i] <= cells_next[i];
    end
  end

  // fill count and dropped flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.shift) begin
      count <= count - CNT_W'(1);
      if (status.last_one) begin
        dropped <= 1'b0;
      end
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // result value comes straight from the head cell; last and overflow from the fill count and dropped flag
  assign head_value = cells[0];
  assign last_out   = status.last_one;
  assign overflow   = dropped;

  // checks
  `IBS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(MAX_ITEMS), "fill count beyond capacity")
  `IBS_ASSERT_SAME(a_row_ascending, cmd.shift && count > CNT_W'(1), cells[0] <= cells[1], "sorted row out of order at head")
  `IBS_ASSERT_NEXT(a_shift_drains, cmd.shift, count == $past(count) - CNT_W'(1), "result taken without count decrement")

endmodule
